### hw/rtl/sliding_window_median_top_defines.svh
// Assertion macros used by the verification checker of the median filter.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// Checks that expr holds in the same cycle whenever cond holds.
`define SWM_ASSERT_NOW(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("sliding window median check failed");

// Checks that expr holds in the cycle after cond holds.
`define SWM_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("sliding window median check failed");

`endif

### hw/rtl/swm_pkg.sv
package swm_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W = 7;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 7'd5;

    // Register index, taken from paddr[2].
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic step;
        logic clear;
        logic flush;
        logic full;
    } swm_ctl_t;

endpackage

### hw/rtl/swm_cell.sv
module swm_cell #(
    parameter int AGE_W = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  swm_pkg::swm_ctl_t                  ctl,
    input  logic signed [swm_pkg::DATA_W-1:0]  sample,
    input  logic [AGE_W-1:0]                   oldest_age,
    input  logic                               left_valid,
    input  logic                               left_le,
    input  logic signed [swm_pkg::DATA_W-1:0]  left_val,
    input  logic [AGE_W-1:0]                   left_age,
    input  logic                               left_del,
    input  logic                               right_valid,
    input  logic                               right_le,
    input  logic signed [swm_pkg::DATA_W-1:0]  right_val,
    input  logic [AGE_W-1:0]                   right_age,
    output logic                               eff_valid,
    output logic                               le,
    output logic signed [swm_pkg::DATA_W-1:0]  val,
    output logic [AGE_W-1:0]                   age,
    output logic                               del_out
);
    import swm_pkg::*;

    logic                     valid_reg, valid_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [AGE_W-1:0]         age_reg, age_next;
    logic                     del_self;
    logic                     shift_a;
    logic                     a_valid, a_le, b_valid, b_le;
    logic signed [DATA_W-1:0] a_val, b_val;
    logic [AGE_W-1:0]         a_age, b_age;

    assign eff_valid = valid_reg & ~ctl.clear;
    assign le        = eff_valid & (val_reg <= sample);
    assign val       = val_reg;
    assign age       = age_reg;
    assign del_self  = ctl.full & eff_valid & (age_reg == oldest_age);
    assign del_out   = left_del | del_self;

    // Once the oldest entry at or left of this cell leaves, the survivors shift left by one.
    assign shift_a = left_del | del_self;

    always_comb begin
        if (shift_a) begin
            a_valid = right_valid;
            a_le    = right_le;
            a_val   = right_val;
            a_age   = right_age;
        end else begin
            a_valid = eff_valid;
            a_le    = le;
            a_val   = val_reg;
            a_age   = age_reg;
        end
        if (left_del) begin
            b_valid = eff_valid;
            b_le    = le;
            b_val   = val_reg;
            b_age   = age_reg;
        end else begin
            b_valid = left_valid;
            b_le    = left_le;
            b_val   = left_val;
            b_age   = left_age;
        end
        if (a_le) begin
            valid_next = a_valid;
            val_next   = a_val;
            age_next   = a_age + AGE_W'(1);
        end else if (b_le) begin
            valid_next = 1'b1;
            val_next   = sample;
            age_next   = '0;
        end else begin
            valid_next = b_valid;
            val_next   = b_val;
            age_next   = b_age + AGE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.flush) begin
            valid_reg <= 1'b0;
        end else if (ctl.step) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

### hw/rtl/sliding_window_median_top.sv
// Sliding-window median filter. The block takes one signed 32-bit sample per clock and
// returns the lower median of the last L samples once L samples of the current sequence
// have arrived; L comes from the window_length register, clamped to 1..WINDOW_MAX, and a
// write to it or a sample with start_req set begins a new sequence. The window lives in a
// row of WINDOW_MAX cells that keep the samples sorted, and every cell updates in the
// cycle the sample is accepted, so a new item may be taken in every cycle. A result
// is held by the cell row and a pending flag until it moves into the output register,
// and the slave side stalls only while a finished result cannot move on because the
// output register is full and not being taken.
module sliding_window_median_top #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [swm_pkg::DATA_W-1:0]    s_tdata,   // [31:0] sample
    input  logic [0:0]                    s_tuser,   // [0] start_req
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [swm_pkg::DATA_W-1:0]    m_tdata,   // [31:0] median
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swm_pkg::APB_AW-1:0]    paddr,
    input  logic [swm_pkg::APB_DW-1:0]    pwdata,
    output logic [swm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import swm_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW = $clog2(WINDOW_MAX + 1);

    logic [CFG_W-1:0]         wl_reg;
    logic [LW-1:0]            fill_reg, fill_next;
    logic [LW-1:0]            fill_eff, fill_after;
    logic [LW-1:0]            len_eff;
    logic [AW-1:0]            oldest_age;
    logic [AW-1:0]            mid;
    logic                     pend_reg, pend_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     s_acc, cfg_wr, load_out, full;
    logic signed [DATA_W-1:0] sample;
    swm_ctl_t                 ctl;

    logic                     cell_valid [WINDOW_MAX];
    logic                     cell_le    [WINDOW_MAX];
    logic signed [DATA_W-1:0] cell_val   [WINDOW_MAX];
    logic [AW-1:0]            cell_age   [WINDOW_MAX];
    logic                     cell_del   [WINDOW_MAX];

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_WINDOW_LENGTH);
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? {{(APB_DW-CFG_W){1'b0}}, wl_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg <= WINDOW_LENGTH_RESET;
        end else if (cfg_wr) begin
            wl_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (wl_reg == '0) begin
            len_eff = LW'(1);
        end else if (int'(wl_reg) > WINDOW_MAX) begin
            len_eff = LW'(WINDOW_MAX);
        end else begin
            len_eff = LW'(wl_reg);
        end
    end

    assign oldest_age = AW'(len_eff - LW'(1));
    assign mid        = AW'((len_eff - LW'(1)) >> 1);

    assign sample   = $signed(s_tdata);
    assign load_out = pend_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~pend_reg | ~out_valid_reg | m_tready;
    assign s_acc    = s_tvalid & s_tready;

    assign fill_eff   = s_tuser[0] ? '0 : fill_reg;
    assign full       = (fill_eff == len_eff);
    assign fill_after = full ? fill_eff : fill_eff + LW'(1);

    assign ctl.step  = s_acc;
    assign ctl.clear = s_tuser[0];
    assign ctl.flush = cfg_wr;
    assign ctl.full  = full;

    always_comb begin
        fill_next = fill_reg;
        if (cfg_wr) begin
            fill_next = '0;
        end else if (s_acc) begin
            fill_next = fill_after;
        end

        pend_next = pend_reg;
        if (s_acc) begin
            pend_next = (fill_after == len_eff);
        end else if (load_out) begin
            pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= cell_val[mid];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic                     l_valid, l_le, l_del, r_valid, r_le;
        logic signed [DATA_W-1:0] l_val, r_val;
        logic [AW-1:0]            l_age, r_age;

        if (i == 0) begin : g_first
            // The first cell always has room to its left for the new sample.
            assign l_valid = 1'b1;
            assign l_le    = 1'b1;
            assign l_val   = '0;
            assign l_age   = '0;
            assign l_del   = 1'b0;
        end else begin : g_inner_l
            assign l_valid = cell_valid[i-1];
            assign l_le    = cell_le[i-1];
            assign l_val   = cell_val[i-1];
            assign l_age   = cell_age[i-1];
            assign l_del   = cell_del[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_last
            assign r_valid = 1'b0;
            assign r_le    = 1'b0;
            assign r_val   = '0;
            assign r_age   = '0;
        end else begin : g_inner_r
            assign r_valid = cell_valid[i+1];
            assign r_le    = cell_le[i+1];
            assign r_val   = cell_val[i+1];
            assign r_age   = cell_age[i+1];
        end

        swm_cell #(
            .AGE_W (AW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .sample      (sample),
            .oldest_age  (oldest_age),
            .left_valid  (l_valid),
            .left_le     (l_le),
            .left_val    (l_val),
            .left_age    (l_age),
            .left_del    (l_del),
            .right_valid (r_valid),
            .right_le    (r_le),
            .right_val   (r_val),
            .right_age   (r_age),
            .eff_valid   (cell_valid[i]),
            .le          (cell_le[i]),
            .val         (cell_val[i]),
            .age         (cell_age[i]),
            .del_out     (cell_del[i])
        );
    end

endmodule

### hw/rtl/swm_checker.sv
`include "sliding_window_median_top_defines.svh"

module swm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [swm_pkg::DATA_W-1:0]    m_tdata
);
    import swm_pkg::*;

    logic s_acc;

    assign s_acc = s_tvalid & s_tready;

    // A waiting result keeps its value until it is taken.
    `SWM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The input side stalls only behind a blocked output register.
    `SWM_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // A fresh result follows an accepted item that completed a window.
    `SWM_ASSERT_NOW(a_result_latency, aclk, aresetn, $rose(m_tvalid), $past(s_acc, 2))

    // With the output free, the input side is always ready.
    `SWM_ASSERT_NOW(a_ready_when_free, aclk, aresetn, !m_tvalid, s_tready)

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (.*);
